### src/pnc_pkg.sv
`timescale 1ns / 1ps
package pnc_pkg;
  localparam int WindowLen  = 32;
  localparam int SampleBits = 16;
  localparam int FracBits   = 15;
  localparam int NumBits    = SampleBits + 3;
  localparam int EnergyBits = 2 * SampleBits + $clog2(WindowLen) + 1;
  localparam int QBits      = FracBits + 1;
  localparam int FillBits   = $clog2(WindowLen + 1);
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);

  typedef struct packed {
    logic [NumBits-1:0]    num;
    logic [EnergyBits-1:0] energy;
  } job_t;

  typedef enum logic [1:0] {ST_IDLE, ST_SQUARE, ST_SEARCH, ST_DONE} div_state_t;

  function automatic logic tap_hit(input int idx);
    return idx == 0 || idx == 1 || idx == 4 || idx == 5 ||
           idx == 14 || idx == 15 || idx == 18 || idx == 19;
  endfunction
endpackage

### src/pnc_front.sv
`timescale 1ns / 1ps
module pnc_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic [pnc_pkg::SampleBits-1:0]  in_sample,
  output logic                            job_valid,
  output pnc_pkg::job_t                   job
);
  logic [pnc_pkg::SampleBits-1:0] win_r [pnc_pkg::WindowLen];
  logic [pnc_pkg::EnergyBits-1:0] energy_r, energy_nxt;
  logic [pnc_pkg::FillBits-1:0]   fill_r;
  logic                           full;
  logic [pnc_pkg::SampleBits-1:0] next_win [pnc_pkg::WindowLen];
  logic [pnc_pkg::NumBits-1:0]    num;
  logic [2*pnc_pkg::SampleBits-1:0] sq_in, sq_old;

  assign full   = (fill_r == pnc_pkg::FillBits'(pnc_pkg::WindowLen));
  assign sq_in  = in_sample * in_sample;
  assign sq_old = win_r[0] * win_r[0];

  always_comb begin
    for (int i = 0; i < pnc_pkg::WindowLen; i++) begin
      if (full) begin
        next_win[i] = (i == pnc_pkg::WindowLen - 1) ? in_sample
                                                    : win_r[(i + 1) % pnc_pkg::WindowLen];
      end else begin
        next_win[i] = (fill_r == pnc_pkg::FillBits'(i)) ? in_sample : win_r[i];
      end
    end
    energy_nxt = energy_r + pnc_pkg::EnergyBits'(sq_in)
               - (full ? pnc_pkg::EnergyBits'(sq_old) : '0);
    num = '0;
    for (int i = 0; i < pnc_pkg::WindowLen; i++) begin
      if (pnc_pkg::tap_hit(i)) num = num + pnc_pkg::NumBits'(next_win[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      energy_r  <= '0;
      job_valid <= 1'b0;
      for (int i = 0; i < pnc_pkg::WindowLen; i++) win_r[i] <= '0;
    end else begin
      job_valid <= 1'b0;
      if (in_push) begin
        win_r    <= next_win;
        energy_r <= energy_nxt;
        if (!full) fill_r <= fill_r + 1'b1;
        job_valid <= full || (fill_r == pnc_pkg::FillBits'(pnc_pkg::WindowLen - 1));
        job.num    <= num;
        job.energy <= energy_nxt;
      end
    end
  end
endmodule

### src/pnc_queue.sv
`timescale 1ns / 1ps
module pnc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  pnc_pkg::job_t wr_data,
  input  logic          rd_en,
  output pnc_pkg::job_t rd_data,
  output logic          empty,
  output logic [pnc_pkg::QPtrBits:0] count
);
  pnc_pkg::job_t mem_r [pnc_pkg::QueueDepth];
  logic [pnc_pkg::QPtrBits-1:0] wp_r, rp_r;
  logic [pnc_pkg::QPtrBits:0]   cnt_r;

  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) begin
        mem_r[wp_r] <= wr_data;
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (pnc_pkg::QPtrBits+1)'(wr_en) - (pnc_pkg::QPtrBits+1)'(rd_en);
    end
  end
endmodule

### src/pnc_back.sv
`timescale 1ns / 1ps
module pnc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          job_ready,
  input  pnc_pkg::job_t                 job,
  output logic                          job_take,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [15:0]                   out_metric
);
  localparam int SqBits  = 2 * pnc_pkg::NumBits + 2 * pnc_pkg::FracBits;
  localparam int EBits   = pnc_pkg::EnergyBits + 3;
  localparam int PBits   = 2 * pnc_pkg::QBits + EBits;
  localparam int LhsBits = (PBits > SqBits) ? PBits : SqBits;
  localparam int ELoBits = 21;
  localparam int EHiBits = EBits - ELoBits;

  pnc_pkg::div_state_t st_r, st_nxt;
  logic [pnc_pkg::NumBits-1:0]    num_r;
  logic [2*pnc_pkg::NumBits-1:0]  nsq;
  logic [EBits-1:0]               e8_r;
  logic [SqBits-1:0]              rhs_r, rhs_nxt;
  logic [pnc_pkg::QBits-1:0]      q_r, q_nxt;
  logic [$clog2(pnc_pkg::QBits+1)-1:0] bit_r, bit_nxt;
  logic [pnc_pkg::QBits-1:0]      trial;
  logic [2*pnc_pkg::QBits-1:0]    tsq_r, tsq_nxt;
  logic [2*pnc_pkg::QBits+ELoBits-1:0] plo_r, plo_nxt;
  logic [2*pnc_pkg::QBits+EHiBits-1:0] phi;
  logic [1:0]                     phase_r, phase_nxt;
  logic                           res_valid_r, res_valid_nxt;
  logic [15:0]                    res_r, res_nxt;
  logic [PBits-1:0]               lhs;
  logic                           zero_e;

  assign zero_e    = (job.energy == '0);
  assign out_empty = !res_valid_r;
  assign out_metric = res_r;
  assign trial = q_r | (pnc_pkg::QBits'(1) << bit_r);
  assign nsq   = num_r * num_r;
  assign phi   = tsq_r * e8_r[EBits-1:ELoBits];
  assign lhs   = {phi, {ELoBits{1'b0}}} + PBits'(plo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pnc_pkg::ST_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      res_valid_r <= res_valid_nxt;
    end
    rhs_r <= rhs_nxt; q_r <= q_nxt; bit_r <= bit_nxt;
    tsq_r <= tsq_nxt; plo_r <= plo_nxt; phase_r <= phase_nxt; res_r <= res_nxt;
    if (st_r == pnc_pkg::ST_IDLE && job_ready && !(res_valid_r && !out_pop)) begin
      num_r <= job.num;
      e8_r  <= {job.energy, 3'b000};
    end
  end

  always_comb begin
    st_nxt = st_r; rhs_nxt = rhs_r; q_nxt = q_r; bit_nxt = bit_r;
    tsq_nxt = tsq_r; plo_nxt = plo_r; phase_nxt = phase_r; res_nxt = res_r;
    res_valid_nxt = res_valid_r && !out_pop;
    job_take = 1'b0;
    case (st_r)
      pnc_pkg::ST_IDLE: begin
        if (job_ready && !(res_valid_r && !out_pop)) begin
          job_take = 1'b1;
          if (zero_e) begin
            res_nxt = '0; res_valid_nxt = 1'b1;
          end else begin
            st_nxt = pnc_pkg::ST_SQUARE;
          end
        end
      end
      pnc_pkg::ST_SQUARE: begin
        rhs_nxt = SqBits'(nsq) << (2 * pnc_pkg::FracBits);
        q_nxt = '0;
        bit_nxt = ($bits(bit_r))'(pnc_pkg::QBits - 1);
        phase_nxt = 2'd0;
        st_nxt = pnc_pkg::ST_SEARCH;
      end
      pnc_pkg::ST_SEARCH: begin
        if (phase_r == 2'd0) begin
          tsq_nxt = trial * trial;
          phase_nxt = 2'd1;
        end else if (phase_r == 2'd1) begin
          plo_nxt = tsq_r * e8_r[ELoBits-1:0];
          phase_nxt = 2'd2;
        end else begin
          phase_nxt = 2'd0;
          if (LhsBits'(lhs) <= LhsBits'(rhs_r)) q_nxt = trial;
          if (bit_r == '0) st_nxt = pnc_pkg::ST_DONE;
          else bit_nxt = bit_r - 1'b1;
        end
      end
      pnc_pkg::ST_DONE: begin
        if (!res_valid_nxt) begin
          res_nxt = 16'(q_r);
          res_valid_nxt = 1'b1;
          st_nxt = pnc_pkg::ST_IDLE;
        end
      end
      default: st_nxt = pnc_pkg::ST_IDLE;
    endcase
  end
endmodule

### src/preamble_normalized_correlator_unit.sv
`timescale 1ns / 1ps
// sliding 32-sample window with running energy; once full, each sample word yields
// metric = floor(sum of taps 0,1,4,5,14,15,18,19 * 2^15 / sqrt(8*energy)), 0 for zero
// energy. each word with nonzero energy runs the bit-serial square-root compare loop
// (load, square, then for each of 16 quotient bits a trial square, partial product and
// compare, then hand-off once the output register is free); a zero-energy word skips the
// loop. a 4-entry queue decouples the window front from that loop; full rises at 3 entries.
module preamble_normalized_correlator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [15:0] in_sample,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_metric
);
  logic          job_valid, job_take, q_empty;
  pnc_pkg::job_t job, q_job;
  logic [pnc_pkg::QPtrBits:0] q_count;
  logic          push_ok;

  assign full    = (q_count >= (pnc_pkg::QPtrBits+1)'(pnc_pkg::QueueDepth - 1));
  assign push_ok = push && !full;

  pnc_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(push_ok),
    .in_sample(in_sample[pnc_pkg::SampleBits-1:0]),
    .job_valid(job_valid), .job(job)
  );

  pnc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_en(job_valid), .wr_data(job),
    .rd_en(job_take), .rd_data(q_job), .empty(q_empty), .count(q_count)
  );

  pnc_back u_back (
    .clk(clk), .rst_n(rst_n), .job_ready(!q_empty), .job(q_job),
    .job_take(job_take), .out_empty(empty), .out_pop(pop), .out_metric(out_metric)
  );
endmodule

### sim/tb.sv
`timescale 1ns / 1ps
class metric_scoreboard;
  logic [15:0] window_q[$];
  logic [15:0] metric_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  function automatic logic [15:0] calc_metric();
    logic [63:0] num, energy, e8, num_sq, lo, hi, mid;
    logic [127:0] lhs, rhs;
    num = 0;
    energy = 0;
    foreach (window_q[i]) begin
      energy += 64'(window_q[i]) * 64'(window_q[i]);
    end
    num = 64'(window_q[0]) + window_q[1] + window_q[4] + window_q[5] +
          window_q[14] + window_q[15] + window_q[18] + window_q[19];
    if (energy == 0) return 16'd0;
    e8 = energy * 8;
    num_sq = num * num;
    lo = 0;
    hi = 64'd1 << pnc_pkg::FracBits;
    while (lo < hi) begin
      mid = lo + ((hi - lo + 1) >> 1);
      lhs = 128'(mid * mid) * 128'(e8);
      rhs = 128'(num_sq) << (2 * pnc_pkg::FracBits);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[15:0];
  endfunction

  function void note_sample(logic [15:0] s);
    window_q.push_back(s);
    if (window_q.size() > pnc_pkg::WindowLen) void'(window_q.pop_front());
    if (window_q.size() == pnc_pkg::WindowLen) metric_q.push_back(calc_metric());
  endfunction

  function void check_metric(logic [15:0] got);
    logic [15:0] want;
    if (metric_q.size() == 0) begin
      $error("unexpected word: metric actual %0d", got);
      errors++;
      return;
    end
    want = metric_q.pop_front();
    if (got !== want) begin
      $error("metric mismatch: expected %0d actual %0d", want, got);
      errors++;
    end
  endfunction
endclass

module tb;
  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic [15:0] in_sample = 0;
  logic pop = 0;
  logic full, empty;
  logic [15:0] out_metric;
  bit quiet = 0;
  bit hold_rx = 0;
  metric_scoreboard sb = new();

  preamble_normalized_correlator_unit DUT (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(full), .in_sample(in_sample),
    .empty(empty), .pop(pop), .out_metric(out_metric)
  );

  always #2 clk = ~clk;

  task automatic send_sample(logic [15:0] s);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_push <= 0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1;
    in_sample <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_sample(s);
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 15));
      3: return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_metric(out_metric);
  end

  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      if (hold_rx) begin
        pop <= 0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
        hold_rx = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        pop <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        pop <= 1;
        @(posedge clk);
      end
    end
  end

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 40; i++) send_sample(16'h0000);
    for (int i = 0; i < 34; i++) send_sample(16'hFFFF);
    for (int i = 0; i < 34; i++) send_sample((i % 2) ? 16'h0000 : 16'hFFFF);
    for (int i = 0; i < 20; i++) send_sample(16'h0001);
    hold_rx = 1;
    for (int i = 0; i < 300; i++) send_sample(rand_sample());
    for (int i = 0; i < 800; i++) begin
      if (i % 64 < 20) send_sample((i % 4 < 2) ? 16'($urandom_range(30000, 65535))
                                               : 16'($urandom_range(0, 200)));
      else send_sample(rand_sample());
    end
    quiet = 1;
    for (int i = 0; i < 200; i++) send_sample(rand_sample());
    in_push <= 0;
    waited = 0;
    while (sb.metric_q.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.metric_q.size() == 0) begin
      $display("** preamble_normalized_correlator_unit: PASSED **");
    end else begin
      $display("** preamble_normalized_correlator_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** preamble_normalized_correlator_unit: FAILED **");
    $finish;
  end
endmodule

### filelist.f
src/pnc_pkg.sv
src/pnc_front.sv
src/pnc_queue.sv
src/pnc_back.sv
src/preamble_normalized_correlator_unit.sv
sim/tb.sv
